@@ src/ntl_pkg.sv @@
package ntl_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned RSSI_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 7;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd10000;
  localparam logic [TIME_W-1:0] TIME_MAX    = 32'hFFFF_FFFF;

  // Operation codes; code 3 carries no operation
  typedef enum logic [FUNC_W-1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_LIST   = 2'd2
  } ntl_func_e;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic signed [RSSI_W-1:0] rssi;
    logic [TIME_W-1:0]        stamp;
  } ntl_slot_t;

  typedef struct packed {
    logic req_ready;
    logic load;
    logic step;
    logic push_pend;
    logic push_final;
    logic write;
  } ntl_cmd_t;

  typedef struct packed {
    logic              req_valid;
    logic [FUNC_W-1:0] req_func;
    ntl_func_e         op_func;
    logic              scan_done;
    logic              push_req;
    logic              out_free;
  } ntl_status_t;

endpackage

@@ src/ntl_if.sv @@
interface ntl_req_if import ntl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [ADDR_W-1:0]        addr;
  logic signed [RSSI_W-1:0] rssi;
  logic [TIME_W-1:0]        now_ms;
  logic [COUNT_W-1:0]       max_entries;

  modport source (output valid, func, addr, rssi, now_ms, max_entries, input ready);
  modport sink (input valid, func, addr, rssi, now_ms, max_entries, output ready);
endinterface

interface ntl_rsp_if import ntl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        out_addr;
  logic signed [RSSI_W-1:0] out_rssi;
  logic                     valid_res;
  logic                     last;

  modport source (output valid, out_addr, out_rssi, valid_res, last, input ready);
  modport sink (input valid, out_addr, out_rssi, valid_res, last, output ready);
endinterface

@@ src/ntl_ctrl.sv @@
module ntl_ctrl import ntl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ntl_status_t status_i,
  output ntl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } ntl_state_e;

  ntl_state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.req_ready = 1'b1;
        if (status_i.req_valid) begin
          cmd_o.load = 1'b1;
          unique case (status_i.req_func)
            FUNC_UPDATE, FUNC_QUERY, FUNC_LIST: state_d = ST_SCAN;
            default:                            state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_FIN;
        end else begin
          // hold the scan while the held list entry waits on a busy output
          cmd_o.step      = !status_i.push_req || status_i.out_free;
          cmd_o.push_pend = status_i.push_req && status_i.out_free;
        end
      end
      ST_FIN: begin
        unique case (status_i.op_func)
          FUNC_UPDATE: begin
            cmd_o.write = 1'b1;
            state_d     = ST_IDLE;
          end
          FUNC_QUERY, FUNC_LIST: begin
            if (status_i.out_free) begin
              cmd_o.push_final = 1'b1;
              state_d          = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/ntl_datapath.sv @@
module ntl_datapath import ntl_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  ntl_req_if.sink           req_i,
  ntl_rsp_if.source         rsp_o,
  input  ntl_cmd_t          cmd_i,
  output ntl_status_t       status_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  ntl_slot_t          slot_mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;
  logic [TIME_W-1:0]  timeout_q;

  // captured request
  ntl_func_e                func_q;
  logic [ADDR_W-1:0]        addr_q;
  logic signed [RSSI_W-1:0] rssi_q;
  logic [TIME_W-1:0]        now_q;
  logic [COUNT_W-1:0]       maxc_q;

  // scan pipeline
  logic [CNT_W-1:0] rd_idx_q;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_done;
  logic             rd_en;
  ntl_slot_t        rdata_q;
  logic             rvld_q;
  logic [IDX_W-1:0] eval_idx_q;
  logic             eval_vld_q;
  logic             eval_en;

  // scan accumulators
  logic                     match_q;
  logic [IDX_W-1:0]         match_idx_q;
  logic signed [RSSI_W-1:0] match_rssi_q;
  logic                     match_fresh_q;
  logic                     empty_q;
  logic [IDX_W-1:0]         empty_idx_q;
  logic [TIME_W-1:0]        best_q;
  logic [IDX_W-1:0]         victim_q;
  logic                     pending_q;
  logic [ADDR_W-1:0]        pend_addr_q;
  logic signed [RSSI_W-1:0] pend_rssi_q;
  logic [COUNT_W-1:0]       cnt_q;

  // output register
  logic                     rsp_valid_q;
  logic [ADDR_W-1:0]        out_addr_q;
  logic signed [RSSI_W-1:0] out_rssi_q;
  logic                     out_vres_q;
  logic                     out_last_q;

  logic [TIME_W-1:0] age;
  logic              fresh;
  logic              hit;
  logic              list_hit;
  logic              is_list;
  logic              out_free;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  ntl_slot_t         wr_data;

  assign rd_addr  = rd_idx_q[IDX_W-1:0];
  assign rd_done  = (rd_idx_q == CNT_W'(SLOT_COUNT));
  assign rd_en    = cmd_i.step && !rd_done;
  assign eval_en  = cmd_i.step && eval_vld_q;

  assign age      = now_q - rdata_q.stamp;
  assign fresh    = (age < timeout_q);
  assign hit      = rvld_q && (rdata_q.addr == addr_q);
  assign is_list  = (func_q == FUNC_LIST);
  assign list_hit = is_list && rvld_q && fresh && (cnt_q < maxc_q);
  assign out_free = !rsp_valid_q || rsp_o.ready;

  // the slot that already holds the address first, then the last empty slot, else the oldest
  assign wr_en   = cmd_i.write && (addr_q != '0);
  assign wr_idx  = match_q ? match_idx_q : (empty_q ? empty_idx_q : victim_q);
  assign wr_data = '{addr: addr_q, rssi: rssi_q, stamp: now_q};

  assign req_i.ready = cmd_i.req_ready;

  assign status_o.req_valid = req_i.valid;
  assign status_o.req_func  = req_i.func;
  assign status_o.op_func   = func_q;
  assign status_o.scan_done = rd_done && !eval_vld_q;
  assign status_o.push_req  = eval_vld_q && list_hit && pending_q;
  assign status_o.out_free  = out_free;

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.out_addr  = out_addr_q;
  assign rsp_o.out_rssi  = out_rssi_q;
  assign rsp_o.valid_res = out_vres_q;
  assign rsp_o.last      = out_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= slot_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RST;
      valid_q     <= '0;
      rd_idx_q    <= '0;
      eval_vld_q  <= 1'b0;
      match_q     <= 1'b0;
      empty_q     <= 1'b0;
      pending_q   <= 1'b0;
      cnt_q       <= '0;
      maxc_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.load) begin
        rd_idx_q   <= '0;
        eval_vld_q <= 1'b0;
        match_q    <= 1'b0;
        empty_q    <= 1'b0;
        pending_q  <= 1'b0;
        cnt_q      <= '0;
        maxc_q     <= req_i.max_entries;
      end else if (cmd_i.step) begin
        if (!rd_done) begin
          rd_idx_q   <= rd_idx_q + CNT_W'(1);
          eval_vld_q <= 1'b1;
        end else begin
          eval_vld_q <= 1'b0;
        end
        if (eval_vld_q) begin
          if (hit) begin
            match_q <= 1'b1;
          end
          if (!rvld_q) begin
            empty_q <= 1'b1;
          end
          if (list_hit) begin
            pending_q <= 1'b1;
            cnt_q     <= cnt_q + COUNT_W'(1);
          end
        end
      end
      if (cmd_i.push_pend || cmd_i.push_final) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= ntl_func_e'(req_i.func);
      addr_q   <= req_i.addr;
      rssi_q   <= req_i.rssi;
      now_q    <= req_i.now_ms;
      best_q   <= TIME_MAX;
      victim_q <= '0;
    end else if (eval_en) begin
      if (hit && !match_q) begin
        match_idx_q   <= eval_idx_q;
        match_rssi_q  <= rdata_q.rssi;
        match_fresh_q <= fresh;
      end
      if (!rvld_q) begin
        empty_idx_q <= eval_idx_q;
      end else if (rdata_q.stamp < best_q) begin
        best_q   <= rdata_q.stamp;
        victim_q <= eval_idx_q;
      end
      if (list_hit) begin
        pend_addr_q <= rdata_q.addr;
        pend_rssi_q <= rdata_q.rssi;
      end
    end
    if (rd_en) begin
      rvld_q     <= valid_q[rd_addr];
      eval_idx_q <= rd_addr;
    end
    if (cmd_i.push_pend) begin
      out_addr_q <= pend_addr_q;
      out_rssi_q <= pend_rssi_q;
      out_vres_q <= 1'b1;
      out_last_q <= 1'b0;
    end else if (cmd_i.push_final) begin
      out_last_q <= 1'b1;
      if (!is_list) begin
        out_addr_q <= addr_q;
        out_rssi_q <= match_q ? match_rssi_q : '0;
        out_vres_q <= match_q && match_fresh_q;
      end else if (pending_q) begin
        out_addr_q <= pend_addr_q;
        out_rssi_q <= pend_rssi_q;
        out_vres_q <= 1'b1;
      end else begin
        out_addr_q <= '0;
        out_rssi_q <= '0;
        out_vres_q <= 1'b0;
      end
    end
  end

  a_write_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> rd_done && !eval_vld_q)
    else $error("table write before the scan finished");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= maxc_q)
    else $error("list count exceeds the entry limit");

  a_valid_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(wr_idx)])
    else $error("written slot not marked valid");

  a_pend_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_pend |=> rsp_valid_q && !out_last_q && out_vres_q)
    else $error("intermediate list result malformed");

endmodule

@@ src/neighbor_table_lru.sv @@
// Sequence: an update, query or list request is accepted while idle, scans every slot, then
//   writes the table (update) or puts the closing result in the output register (query,
//   list) before the block is ready again. A list streams entries as the scan finds them.
// Throughput: one request at a time; the slot scan reads one table entry per cycle through
//   the single read port; a stalled output holds the scan.
// Reset: every slot empty (valid bits cleared), timeout 10000 ms, no result pending.
module neighbor_table_lru import ntl_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  ntl_req_if.sink           req_i,
  ntl_rsp_if.source         rsp_o
);

  // Command and status between the sequencer and the table datapath
  ntl_cmd_t    cmd;
  ntl_status_t status;

  // Sequencer: accept a request, run the slot scan, then write the table (update)
  // or push the closing result (query, list). Function code 3 is dropped at accept.
  ntl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath: table memory with per-slot valid bits, the scan pipeline (read one slot into a
  // register, then evaluate it), match / empty / oldest tracking, the one-deep hold
  // for list entries so the final one can be marked last, and the output register.
  ntl_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
